[rtl/ptc_pkg.sv]
// package: types, constants and helpers for the pressure/temperature compensation block
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DivStg   = 32;
  localparam int unsigned PreStg   = 11;
  localparam int unsigned PostStg  = 4;
  localparam int unsigned NumStg   = PreStg + DivStg + PostStg;

  localparam logic [CfgIdxW-1:0] CFG_TEMP       = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LOW  = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HIGH = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_NINE = 8'd3;

  localparam logic [31:0] OFS_FINE  = 32'd64000;
  localparam logic [31:0] OFS_RAW_P = 32'd1048576;
  localparam logic [31:0] SCALE_P   = 32'd3125;
  localparam logic [31:0] HALF_P1   = 32'd32768;
  localparam logic [31:0] RND_T     = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [31:0]        press_pa;
    logic               div_zero;
  } out_word_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    asr = 32'($signed(x) >>> n);
  endfunction

  // low 32 bits of the product
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    mul32 = p[31:0];
  endfunction

endpackage

[rtl/pressure_temp_compensation_int32_top.sv]
// top level: fully pipelined pressure and temperature compensation
`timescale 1ns / 1ps
// Compensates one raw temperature / raw pressure pair per clock using the
// standard 32-bit integer calibration polynomial. The block is one pipeline of
// 47 register stages: 11 for the temperature and pressure polynomial terms (no
// more than one 32x32 multiply deep per stage), 32 for the unsigned restoring
// divider (one quotient bit per stage), and 4 for the final pressure correction
// and the output register. A new word is accepted every cycle while the output
// is not stalled. The whole pipeline moves as one on a shared enable, so when
// the output word is held by the consumer every stage holds and in_ready_o
// drops. When the pressure divisor term is zero the result carries
// press_pa = 0 and div_zero = 1; temperature is always valid.
// Coefficients come from four config registers (index 0..3, others ignored);
// they must only be written while the pipeline is empty. All math wraps at 32
// bits, matching the fixed-point reference formula.
module pressure_temp_compensation_int32_top
  import ptc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // config registers
  logic [47:0] tc_q;
  logic [63:0] pl_q, ph_q;
  logic [15:0] p9c_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q  <= '0;
      pl_q  <= '0;
      ph_q  <= '0;
      p9c_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TEMP)       tc_q  <= cfg_data_i[47:0];
      if (cfg_index_i == CFG_PRESS_LOW)  pl_q  <= cfg_data_i;
      if (cfg_index_i == CFG_PRESS_HIGH) ph_q  <= cfg_data_i;
      if (cfg_index_i == CFG_PRESS_NINE) p9c_q <= cfg_data_i[15:0];
    end
  end

  // unpacked coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, tc_q[15:0]};
  assign t2 = sx16(tc_q[31:16]);
  assign t3 = sx16(tc_q[47:32]);
  assign p1 = {16'd0, pl_q[15:0]};
  assign p2 = sx16(pl_q[31:16]);
  assign p3 = sx16(pl_q[47:32]);
  assign p4 = sx16(pl_q[63:48]);
  assign p5 = sx16(ph_q[15:0]);
  assign p6 = sx16(ph_q[31:16]);
  assign p7 = sx16(ph_q[47:32]);
  assign p8 = sx16(ph_q[63:48]);
  assign p9 = sx16(p9c_q);

  // global pipeline enable: hold everything while the output word waits
  logic              en;
  logic [NumStg-1:0] vld_q;

  assign en          = !vld_q[NumStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  // polynomial section payload
  logic [19:0] rt1_q, rp1_q, rp2_q, rp3_q, rp4_q, rp5_q, rp6_q, rp7_q, rp8_q, rp9_q;
  logic [31:0] x2_q, d2_q, m1_3_q, dd3_q, a4_q, m2_4_q, fine5_q;
  logic [31:0] tmp6_q, pa6_q, tmp7_q, q7_q, a5_7_q, p2a7_q;
  logic [31:0] tmp8_q, b1_8_q, m3_8_q, a5_8_q, p2a8_q;
  logic [31:0] tmp9_q, b9_q, a2_9_q, tmp10_q, a3_10_q, x10_q;
  logic [31:0] tmp11_q, dv11_q, pm11_q;
  logic [31:0] fine_x5;

  assign fine_x5 = (fine5_q << 2) + fine5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      // temperature terms
      rt1_q   <= in_word_i.raw_temp;
      rp1_q   <= in_word_i.raw_press;
      x2_q    <= {15'd0, rt1_q[19:3]} - (t1 << 1);
      d2_q    <= {16'd0, rt1_q[19:4]} - t1;
      rp2_q   <= rp1_q;
      m1_3_q  <= mul32(x2_q, t2);
      dd3_q   <= mul32(d2_q, d2_q);
      rp3_q   <= rp2_q;
      a4_q    <= asr(m1_3_q, 11);
      m2_4_q  <= mul32(asr(dd3_q, 12), t3);
      rp4_q   <= rp3_q;
      fine5_q <= a4_q + asr(m2_4_q, 14);
      rp5_q   <= rp4_q;
      tmp6_q  <= asr(fine_x5 + RND_T, 8);
      pa6_q   <= asr(fine5_q, 1) - OFS_FINE;
      rp6_q   <= rp5_q;
      // pressure terms
      q7_q    <= mul32(asr(pa6_q, 2), asr(pa6_q, 2));
      a5_7_q  <= mul32(pa6_q, p5);
      p2a7_q  <= mul32(p2, pa6_q);
      tmp7_q  <= tmp6_q;
      rp7_q   <= rp6_q;
      b1_8_q  <= mul32(asr(q7_q, 11), p6);
      m3_8_q  <= mul32(p3, asr(q7_q, 13));
      a5_8_q  <= a5_7_q;
      p2a8_q  <= p2a7_q;
      tmp8_q  <= tmp7_q;
      rp8_q   <= rp7_q;
      b9_q    <= asr(b1_8_q + (a5_8_q << 1), 2) + (p4 << 16);
      a2_9_q  <= asr(asr(m3_8_q, 3) + asr(p2a8_q, 1), 18);
      tmp9_q  <= tmp8_q;
      rp9_q   <= rp8_q;
      a3_10_q <= mul32(HALF_P1 + a2_9_q, p1);
      x10_q   <= (OFS_RAW_P - {12'd0, rp9_q}) - asr(b9_q, 12);
      tmp10_q <= tmp9_q;
      dv11_q  <= asr(a3_10_q, 15);
      pm11_q  <= mul32(x10_q, SCALE_P);
      tmp11_q <= tmp10_q;
    end
  end

  // divider: one restoring step per stage, quotient shifts into the dividend
  logic [31:0] num0;
  logic        md0;
  assign md0  = pm11_q[31];
  assign num0 = md0 ? pm11_q : (pm11_q << 1);

  logic [31:0] rem_q [DivStg];
  logic [31:0] nq_q  [DivStg];
  logic [31:0] dv_q  [DivStg];
  logic [31:0] tp_q  [DivStg];
  logic        md_q  [DivStg];
  logic        dz_q  [DivStg];
  logic [31:0] rem_d [DivStg];
  logic [31:0] nq_d  [DivStg];

  always_comb begin
    logic [31:0] prem, pnq, pdv;
    logic [32:0] trial;
    for (int i = 0; i < DivStg; i++) begin
      prem  = (i == 0) ? 32'd0 : rem_q[(i == 0) ? 0 : i - 1];
      pnq   = (i == 0) ? num0 : nq_q[(i == 0) ? 0 : i - 1];
      pdv   = (i == 0) ? dv11_q : dv_q[(i == 0) ? 0 : i - 1];
      trial = {prem, pnq[31]};
      if (trial >= {1'b0, pdv}) begin
        rem_d[i] = 32'(trial - {1'b0, pdv});
        nq_d[i]  = {pnq[30:0], 1'b1};
      end else begin
        rem_d[i] = trial[31:0];
        nq_d[i]  = {pnq[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < DivStg; i++) begin
        rem_q[i] <= rem_d[i];
        nq_q[i]  <= nq_d[i];
      end
      dv_q[0] <= dv11_q;
      tp_q[0] <= tmp11_q;
      md_q[0] <= md0;
      dz_q[0] <= (dv11_q == 32'd0);
      for (int i = 1; i < DivStg; i++) begin
        dv_q[i] <= dv_q[i-1];
        tp_q[i] <= tp_q[i-1];
        md_q[i] <= md_q[i-1];
        dz_q[i] <= dz_q[i-1];
      end
    end
  end

  // final pressure correction
  logic [31:0] p43_q, tmp43_q, p44_q, s44_q, mb44_q, tmp44_q;
  logic [31:0] p45_q, ma45_q, bt45_q, tmp45_q;
  logic        dz43_q, dz44_q, dz45_q;
  out_word_t   out_q;
  logic [31:0] corr;

  assign corr = asr(asr(ma45_q, 12) + bt45_q + p7, 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p43_q   <= md_q[DivStg-1] ? (nq_q[DivStg-1] << 1) : nq_q[DivStg-1];
      tmp43_q <= tp_q[DivStg-1];
      dz43_q  <= dz_q[DivStg-1];
      s44_q   <= mul32(p43_q >> 3, p43_q >> 3);
      mb44_q  <= mul32(p43_q >> 2, p8);
      p44_q   <= p43_q;
      tmp44_q <= tmp43_q;
      dz44_q  <= dz43_q;
      ma45_q  <= mul32(p9, s44_q >> 13);
      bt45_q  <= asr(mb44_q, 13);
      p45_q   <= p44_q;
      tmp45_q <= tmp44_q;
      dz45_q  <= dz44_q;
      out_q.temp_centi <= tmp45_q;
      out_q.press_pa   <= dz45_q ? 32'd0 : (p45_q + corr);
      out_q.div_zero   <= dz45_q;
    end
  end

  assign out_word_o = out_q;

endmodule
